// ===== src/assert_macros.svh =====
// Assertion macros used by the checker in sbdt_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define SBDT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define SBDT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sbdt_pkg.sv =====
package sbdt_pkg;

    // Input word width
    localparam int VALUE_WIDTH = 32;

    // Magnitude padded to an even width, two bits consumed per step
    localparam int MAG_W  = VALUE_WIDTH + (VALUE_WIDTH % 2);
    localparam int STEPS  = MAG_W / 2;
    localparam int STEP_W = $clog2(STEPS + 1);

    // Decimal digits needed for any VALUE_WIDTH-bit magnitude
    localparam int DIGITS    = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W     = DIGITS * 4;
    localparam int DIG_IDX_W = $clog2(DIGITS);

    // Character codes
    localparam int TEXT_W = 6;
    localparam logic [TEXT_W-1:0] CHAR_SPACE = TEXT_W'(32);
    localparam logic [TEXT_W-1:0] CHAR_MINUS = TEXT_W'(45);
    localparam logic [TEXT_W-1:0] CHAR_ZERO  = TEXT_W'(48);
    localparam logic [TEXT_W-1:0] CHAR_NINE  = TEXT_W'(57);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_LEAD,
        ST_MINUS,
        ST_DIGIT,
        ST_TAIL
    } state_t;

    // Controls from the sequencer to the conversion unit
    typedef struct packed {
        logic load;
        logic step;
    } unit_ctrl_t;

endpackage

// ===== src/signed_binary_to_decimal_text.sv =====
// Signed binary to decimal text.
// s_value is a two's complement integer taken on a valid/ready transfer.
// Its decimal text leaves on the m_ channel one ASCII character per
// transfer: a space, a minus sign when negative, the digits most
// significant first without leading zeros (a lone "0" for zero), and a
// closing space marked by m_last_char.
// After a transfer the magnitude is converted by a shift-add-3 unit that
// takes two bits per cycle; s_ready is low from the transfer until the
// closing space is loaded into the output register.
// Characters then leave at one per cycle while m_ready stays high, with
// s_ready rising as the closing space waits to be taken.
// The next value is taken while that closing space is still held.
// A stall on m_ready holds the output register; conversion runs on, but
// the sequencer waits before its next character, so nothing is dropped.
// Reset empties the output register and returns the sequencer to idle
// with s_ready high.
module signed_binary_to_decimal_text (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [sbdt_pkg::VALUE_WIDTH-1:0] s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [sbdt_pkg::TEXT_W-1:0]        m_text_char,
    output logic                               m_last_char
);
    import sbdt_pkg::*;

    state_t               state_reg, state_next;
    logic [STEP_W-1:0]    step_cnt_reg, step_cnt_next;
    logic                 neg_reg, neg_next;
    logic [DIG_IDX_W-1:0] idx_reg, idx_next;
    logic                 m_valid_reg, m_valid_next;
    logic [TEXT_W-1:0]    m_text_reg, m_text_next;
    logic                 m_last_reg, m_last_next;

    unit_ctrl_t           ctrl;
    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] mag;
    logic [BCD_W-1:0]     bcd;
    logic [DIG_IDX_W-1:0] lead_idx;
    logic [3:0]           cur_digit;
    logic                 out_free;

    // Magnitude as unsigned, so the most negative value is exact
    assign raw = s_value;
    assign mag = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;

    sbdt_dabble_unit u_unit (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .load_mag (MAG_W'(mag)),
        .bcd      (bcd)
    );

    // Highest nonzero digit, zero when all digits are zero
    always_comb begin
        lead_idx = '0;
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd[i*4 +: 4] != 4'd0) begin
                lead_idx = DIG_IDX_W'(i);
            end
        end
    end

    assign cur_digit = bcd[idx_reg*4 +: 4];
    assign out_free  = !m_valid_reg || m_ready;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        neg_reg    <= neg_next;
        idx_reg    <= idx_next;
        m_text_reg <= m_text_next;
        m_last_reg <= m_last_next;
    end

    // Sequencer and output register loading
    always_comb begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        neg_next      = neg_reg;
        idx_next      = idx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_text_next   = m_text_reg;
        m_last_next   = m_last_reg;
        ctrl.load     = 1'b0;
        ctrl.step     = 1'b0;
        s_ready       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctrl.load     = 1'b1;
                    neg_next      = raw[VALUE_WIDTH-1];
                    step_cnt_next = '0;
                    state_next    = ST_CONV;
                end
            end
            ST_CONV: begin
                ctrl.step     = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == STEP_W'(STEPS - 1)) begin
                    state_next = ST_LEAD;
                end
            end
            ST_LEAD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_text_next  = CHAR_SPACE;
                    m_last_next  = 1'b0;
                    idx_next     = lead_idx;
                    state_next   = neg_reg ? ST_MINUS : ST_DIGIT;
                end
            end
            ST_MINUS: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_text_next  = CHAR_MINUS;
                    m_last_next  = 1'b0;
                    state_next   = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_text_next  = CHAR_ZERO + TEXT_W'(cur_digit);
                    m_last_next  = 1'b0;
                    if (idx_reg == '0) begin
                        state_next = ST_TAIL;
                    end else begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            ST_TAIL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_text_next  = CHAR_SPACE;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_text_char = m_text_reg;
    assign m_last_char = m_last_reg;

endmodule

// ===== src/sbdt_dabble_unit.sv =====
module sbdt_dabble_unit (
    input  logic                      aclk,
    input  sbdt_pkg::unit_ctrl_t      ctrl,
    input  logic [sbdt_pkg::MAG_W-1:0] load_mag,
    output logic [sbdt_pkg::BCD_W-1:0] bcd
);
    import sbdt_pkg::*;

    logic [MAG_W-1:0] mag_reg;
    logic [BCD_W-1:0] bcd_reg;
    logic [BCD_W-1:0] bcd_half;
    logic [BCD_W-1:0] bcd_full;

    // One shift-add-3 pass: correct each digit, then shift in one bit
    function automatic logic [BCD_W-1:0] dabble_bit(input logic [BCD_W-1:0] b,
                                                     input logic            bit_in);
        logic [BCD_W-1:0] adj;
        adj = b;
        for (int d = 0; d < DIGITS; d++) begin
            if (b[d*4 +: 4] >= 4'd5) begin
                adj[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

    // Two bits per step, most significant first
    always_comb begin
        bcd_half = dabble_bit(bcd_reg, mag_reg[MAG_W-1]);
        bcd_full = dabble_bit(bcd_half, mag_reg[MAG_W-2]);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            mag_reg <= load_mag;
            bcd_reg <= '0;
        end else if (ctrl.step) begin
            mag_reg <= {mag_reg[MAG_W-3:0], 2'b00};
            bcd_reg <= bcd_full;
        end
    end

    assign bcd = bcd_reg;

endmodule

// ===== src/sbdt_checker.sv =====
`include "assert_macros.svh"

module sbdt_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [sbdt_pkg::TEXT_W-1:0] m_text_char,
    input logic                        m_last_char
);
    import sbdt_pkg::*;

    // A stalled character holds
    `SBDT_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_text_char) && $stable(m_last_char), "stalled character changed")

    // Only space, minus or a digit ever leaves
    `SBDT_ASSERT_IMP(a_char_code, m_valid, (m_text_char == CHAR_SPACE) || (m_text_char == CHAR_MINUS) || ((m_text_char >= CHAR_ZERO) && (m_text_char <= CHAR_NINE)), "illegal character code")

    // The text always closes on a space
    `SBDT_ASSERT_IMP(a_last_space, m_valid && m_last_char, m_text_char == CHAR_SPACE, "last character is not a space")

    // Busy converting right after an input transfer
    `SBDT_ASSERT_NXT(a_busy_after_in, s_valid && s_ready, !s_ready, "ready stayed high after input transfer")

endmodule

bind signed_binary_to_decimal_text sbdt_checker u_checker (.*);
